FILE: design/asc_pkg.sv
// Types, codes and constants shared by the alarm snooze controller files.
package asc_pkg;

    localparam int SNOOZE_MINUTES_DEF = 9;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int KIND_W   = 4;

    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY   = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HR  = 6'd60;
    localparam logic [HOUR_W-1:0]   LAST_HOUR       = 5'd23;
    localparam logic [MINUTE_W-1:0] LAST_MINUTE     = 6'd59;
    localparam logic [HOUR_W-1:0]   WAKE_HOUR_RST   = 5'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK    = 4'd0,
        KIND_SET      = 4'd1,
        KIND_ENABLE   = 4'd2,
        KIND_DISMISS  = 4'd3,
        KIND_SNOOZE   = 4'd4,
        KIND_INC_HOUR = 4'd5,
        KIND_INC_MIN  = 4'd6,
        KIND_DEC_HOUR = 4'd7,
        KIND_DEC_MIN  = 4'd8,
        KIND_IDLE     = 4'd9
    } asc_kind_t;

    typedef enum logic [1:0] {
        ST_OFF     = 2'd0,
        ST_ARMED   = 2'd1,
        ST_RINGING = 2'd2,
        ST_SNOOZED = 2'd3
    } asc_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HOUR_W-1:0]   hours;
        logic [MINUTE_W-1:0] minutes;
        logic                enable_flag;
    } asc_in_t;

    typedef struct packed {
        logic [1:0]          ctl_state;
        logic                buzzer_on;
        logic                enabled;
        logic [HOUR_W-1:0]   alarm_hour;
        logic [MINUTE_W-1:0] alarm_minute;
    } asc_out_t;

    typedef struct packed {
        asc_state_t          mode;
        logic [HOUR_W-1:0]   wake_hour;
        logic [MINUTE_W-1:0] wake_minute;
        logic [HOUR_W-1:0]   snooze_hour;
        logic [MINUTE_W-1:0] snooze_minute;
        logic                enable;
    } asc_regs_t;

endpackage

FILE: design/alarm_snooze_controller.sv
// Top level of the alarm snooze controller: input stage, state and result register.
//
// Usage: each s_ transaction carries one event (check, set, enable write,
// dismiss, snooze, alarm time step, idle). Every event yields exactly one
// m_ transaction with the controller state, buzzer, enable flag and alarm
// time as they stand after that event, in event order.
// Order: an accepted event is first held in the input stage, then applied
// to the state and the result register together once the result register
// is free, and its result is offered on m_ from then on.
// Throughput: one event per cycle while m_ready stays high, set by the single
// state update stage; s_ready stays high while the result register drains.
// Reset: aresetn low clears both stages and loads off state, alarm 07:00,
// snooze time 00:00 and enable flag 0.
// Stall: while m_ready is low the result holds; one more event waits in
// the input stage, after which s_ready drops until the result is taken.
module alarm_snooze_controller #(
    parameter int SNOOZE_MINUTES = asc_pkg::SNOOZE_MINUTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  asc_pkg::asc_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output asc_pkg::asc_out_t m_payload
);

    logic               in_valid_reg;
    asc_pkg::asc_in_t   in_reg;
    logic               out_valid_reg;
    asc_pkg::asc_out_t  out_reg;
    asc_pkg::asc_regs_t regs_reg;
    asc_pkg::asc_regs_t regs_next;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    asc_event #(
        .SNOOZE_MINUTES(SNOOZE_MINUTES)
    ) u_event (
        .cur(regs_reg),
        .evt(in_reg),
        .nxt(regs_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.mode          <= asc_pkg::ST_OFF;
            regs_reg.wake_hour     <= asc_pkg::WAKE_HOUR_RST;
            regs_reg.wake_minute   <= '0;
            regs_reg.snooze_hour   <= '0;
            regs_reg.snooze_minute <= '0;
            regs_reg.enable        <= 1'b0;
        end else if (advance) begin
            regs_reg <= regs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_payload;
        end
        if (advance) begin
            out_reg.ctl_state    <= regs_next.mode;
            out_reg.buzzer_on    <= (regs_next.mode == asc_pkg::ST_RINGING);
            out_reg.enabled      <= regs_next.enable;
            out_reg.alarm_hour   <= regs_next.wake_hour;
            out_reg.alarm_minute <= regs_next.wake_minute;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

FILE: design/asc_event.sv
// Next-state logic of the alarm controller for one event.
module asc_event #(
    parameter int SNOOZE_MINUTES = asc_pkg::SNOOZE_MINUTES_DEF
) (
    input  asc_pkg::asc_regs_t cur,
    input  asc_pkg::asc_in_t   evt,
    output asc_pkg::asc_regs_t nxt
);

    localparam logic [asc_pkg::MINUTE_W:0] SnoozeAdd =
        (asc_pkg::MINUTE_W+1)'(SNOOZE_MINUTES % 60);

    logic [asc_pkg::MINUTE_W:0]   snz_sum;
    logic [asc_pkg::HOUR_W-1:0]   snz_hour;
    logic [asc_pkg::MINUTE_W-1:0] snz_minute;
    logic [asc_pkg::HOUR_W-1:0]   hour_inc;
    logic [asc_pkg::HOUR_W-1:0]   hour_dec;
    logic [asc_pkg::MINUTE_W-1:0] minute_inc;
    logic [asc_pkg::MINUTE_W-1:0] minute_dec;
    logic [asc_pkg::HOUR_W-1:0]   set_hour;
    logic [asc_pkg::MINUTE_W-1:0] set_minute;
    logic                         wake_match;
    logic                         snz_match;

    assign hour_inc   = (cur.wake_hour == asc_pkg::LAST_HOUR) ? '0 : cur.wake_hour + 1'b1;
    assign hour_dec   = (cur.wake_hour == '0) ? asc_pkg::LAST_HOUR : cur.wake_hour - 1'b1;
    assign minute_inc = (cur.wake_minute == asc_pkg::LAST_MINUTE) ? '0
                                                                  : cur.wake_minute + 1'b1;
    assign minute_dec = (cur.wake_minute == '0) ? asc_pkg::LAST_MINUTE
                                                : cur.wake_minute - 1'b1;

    assign set_hour   = (evt.hours >= asc_pkg::HOURS_PER_DAY)
                      ? evt.hours - asc_pkg::HOURS_PER_DAY : evt.hours;
    assign set_minute = (evt.minutes >= asc_pkg::MINUTES_PER_HR)
                      ? evt.minutes - asc_pkg::MINUTES_PER_HR : evt.minutes;

    assign snz_sum = {1'b0, cur.wake_minute} + SnoozeAdd;

    always_comb begin
        if (snz_sum >= {1'b0, asc_pkg::MINUTES_PER_HR}) begin
            snz_minute = asc_pkg::MINUTE_W'(snz_sum - {1'b0, asc_pkg::MINUTES_PER_HR});
            snz_hour   = hour_inc;
        end else begin
            snz_minute = snz_sum[asc_pkg::MINUTE_W-1:0];
            snz_hour   = cur.wake_hour;
        end
    end

    assign wake_match = (evt.hours == cur.wake_hour) && (evt.minutes == cur.wake_minute);
    assign snz_match  = (evt.hours == cur.snooze_hour) && (evt.minutes == cur.snooze_minute);

    always_comb begin
        nxt = cur;
        unique case (evt.kind)
            asc_pkg::KIND_CHECK: begin
                if ((cur.mode == asc_pkg::ST_ARMED && wake_match) ||
                    (cur.mode == asc_pkg::ST_SNOOZED && snz_match)) begin
                    nxt.mode = asc_pkg::ST_RINGING;
                end
            end
            asc_pkg::KIND_SET: begin
                nxt.wake_hour   = set_hour;
                nxt.wake_minute = set_minute;
            end
            asc_pkg::KIND_ENABLE: begin
                nxt.enable = evt.enable_flag;
                if (!evt.enable_flag) begin
                    nxt.mode = asc_pkg::ST_OFF;
                end else if (cur.mode == asc_pkg::ST_OFF) begin
                    nxt.mode = asc_pkg::ST_ARMED;
                end
            end
            asc_pkg::KIND_DISMISS: begin
                if (cur.mode == asc_pkg::ST_RINGING || cur.mode == asc_pkg::ST_SNOOZED) begin
                    nxt.mode = asc_pkg::ST_ARMED;
                end
            end
            asc_pkg::KIND_SNOOZE: begin
                if (cur.mode == asc_pkg::ST_RINGING) begin
                    nxt.mode          = asc_pkg::ST_SNOOZED;
                    nxt.snooze_hour   = snz_hour;
                    nxt.snooze_minute = snz_minute;
                end
            end
            asc_pkg::KIND_INC_HOUR: nxt.wake_hour   = hour_inc;
            asc_pkg::KIND_INC_MIN:  nxt.wake_minute = minute_inc;
            asc_pkg::KIND_DEC_HOUR: nxt.wake_hour   = hour_dec;
            asc_pkg::KIND_DEC_MIN:  nxt.wake_minute = minute_dec;
            default: begin
            end
        endcase
    end

endmodule

FILE: design/asc_checker.sv
// Port-level assertions for the alarm snooze controller and their bind.
module asc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input asc_pkg::asc_out_t m_payload
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    a_buzzer_ringing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.buzzer_on == (m_payload.ctl_state == asc_pkg::ST_RINGING))
        else $error("buzzer disagrees with state");

    a_enable_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.enabled == (m_payload.ctl_state != asc_pkg::ST_OFF))
        else $error("enable flag disagrees with state");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.alarm_hour <= asc_pkg::LAST_HOUR &&
                    m_payload.alarm_minute <= asc_pkg::LAST_MINUTE)
        else $error("alarm time out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty right after reset");

endmodule

bind alarm_snooze_controller asc_checker u_asc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_payload(m_payload)
);

FILE: test/tb.sv
// Testbench for the alarm snooze controller: directed and random events against a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT = 2000;

    typedef logic [asc_pkg::KIND_W-1:0]   kind_bits_t;
    typedef logic [asc_pkg::HOUR_W-1:0]   hour_bits_t;
    typedef logic [asc_pkg::MINUTE_W-1:0] minute_bits_t;

    localparam kind_bits_t KIND_UNUSED = '1;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    asc_pkg::asc_in_t  s_payload = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    asc_pkg::asc_out_t m_payload;

    asc_pkg::asc_state_t alarm_mode;
    hour_bits_t          wake_hour;
    minute_bits_t        wake_minute;
    hour_bits_t          snooze_hour;
    minute_bits_t        snooze_minute;
    logic                enable_bit;

    asc_pkg::asc_out_t expected_status[$];
    asc_pkg::asc_out_t want;
    int                mismatch_count = 0;
    int                stall_cycles = 0;
    bit                idle_on = 1'b1;

    alarm_snooze_controller #(
        .SNOOZE_MINUTES(asc_pkg::SNOOZE_MINUTES_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void reset_alarm_model();
        alarm_mode    = asc_pkg::ST_OFF;
        wake_hour     = asc_pkg::WAKE_HOUR_RST;
        wake_minute   = '0;
        snooze_hour   = '0;
        snooze_minute = '0;
        enable_bit    = 1'b0;
    endfunction

    function automatic asc_pkg::asc_out_t advance_alarm(input asc_pkg::asc_in_t ev);
        asc_pkg::asc_out_t res;
        int                snz;
        unique case (ev.kind)
            asc_pkg::KIND_CHECK: begin
                if (alarm_mode == asc_pkg::ST_ARMED) begin
                    if (ev.hours == wake_hour && ev.minutes == wake_minute)
                        alarm_mode = asc_pkg::ST_RINGING;
                end else if (alarm_mode == asc_pkg::ST_SNOOZED) begin
                    if (ev.hours == snooze_hour && ev.minutes == snooze_minute)
                        alarm_mode = asc_pkg::ST_RINGING;
                end
            end
            asc_pkg::KIND_SET: begin
                wake_hour   = ev.hours % asc_pkg::HOURS_PER_DAY;
                wake_minute = ev.minutes % asc_pkg::MINUTES_PER_HR;
            end
            asc_pkg::KIND_ENABLE: begin
                enable_bit = ev.enable_flag;
                if (ev.enable_flag) begin
                    if (alarm_mode == asc_pkg::ST_OFF)
                        alarm_mode = asc_pkg::ST_ARMED;
                end else begin
                    alarm_mode = asc_pkg::ST_OFF;
                end
            end
            asc_pkg::KIND_DISMISS: begin
                if (alarm_mode == asc_pkg::ST_RINGING || alarm_mode == asc_pkg::ST_SNOOZED)
                    alarm_mode = asc_pkg::ST_ARMED;
            end
            asc_pkg::KIND_SNOOZE: begin
                if (alarm_mode == asc_pkg::ST_RINGING) begin
                    snz = int'(wake_minute) +
                          asc_pkg::SNOOZE_MINUTES_DEF % int'(asc_pkg::MINUTES_PER_HR);
                    snooze_hour = wake_hour;
                    if (snz >= int'(asc_pkg::MINUTES_PER_HR)) begin
                        snz = snz - int'(asc_pkg::MINUTES_PER_HR);
                        snooze_hour = (wake_hour == asc_pkg::LAST_HOUR) ? '0
                                                                        : wake_hour + 1'b1;
                    end
                    snooze_minute = snz[asc_pkg::MINUTE_W-1:0];
                    alarm_mode = asc_pkg::ST_SNOOZED;
                end
            end
            asc_pkg::KIND_INC_HOUR:
                wake_hour = (wake_hour == asc_pkg::LAST_HOUR) ? '0 : wake_hour + 1'b1;
            asc_pkg::KIND_INC_MIN:
                wake_minute = (wake_minute == asc_pkg::LAST_MINUTE) ? '0 : wake_minute + 1'b1;
            asc_pkg::KIND_DEC_HOUR:
                wake_hour = (wake_hour == '0) ? asc_pkg::LAST_HOUR : wake_hour - 1'b1;
            asc_pkg::KIND_DEC_MIN:
                wake_minute = (wake_minute == '0) ? asc_pkg::LAST_MINUTE : wake_minute - 1'b1;
            default: ;
        endcase
        res.ctl_state    = alarm_mode;
        res.buzzer_on    = (alarm_mode == asc_pkg::ST_RINGING);
        res.enabled      = enable_bit;
        res.alarm_hour   = wake_hour;
        res.alarm_minute = wake_minute;
        return res;
    endfunction

    function automatic asc_pkg::asc_in_t make_event(input kind_bits_t kind,
                                                    input int hours, input int minutes,
                                                    input bit enable_flag);
        asc_pkg::asc_in_t ev;
        ev.kind        = kind;
        ev.hours       = hours[asc_pkg::HOUR_W-1:0];
        ev.minutes     = minutes[asc_pkg::MINUTE_W-1:0];
        ev.enable_flag = enable_flag;
        return ev;
    endfunction

    function automatic kind_bits_t pick_step_kind();
        return kind_bits_t'($urandom_range(asc_pkg::KIND_INC_HOUR, asc_pkg::KIND_DEC_MIN));
    endfunction

    function automatic asc_pkg::asc_in_t pick_event();
        asc_pkg::asc_in_t ev;
        int               roll;
        ev.kind        = asc_pkg::KIND_IDLE;
        ev.hours       = hour_bits_t'($urandom_range(0, 2**asc_pkg::HOUR_W - 1));
        ev.minutes     = minute_bits_t'($urandom_range(0, 2**asc_pkg::MINUTE_W - 1));
        ev.enable_flag = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
            ev.kind = kind_bits_t'($urandom_range(0, 2**asc_pkg::KIND_W - 1));
            return ev;
        end
        roll = $urandom_range(0, 99);
        case (alarm_mode)
            asc_pkg::ST_OFF: begin
                if (roll < 50) begin
                    ev.kind = asc_pkg::KIND_ENABLE;
                    ev.enable_flag = (roll < 42);
                end else if (roll < 70) begin
                    ev.kind = asc_pkg::KIND_SET;
                end else if (roll < 90) begin
                    ev.kind = pick_step_kind();
                end else begin
                    ev.kind = asc_pkg::KIND_CHECK;
                end
            end
            asc_pkg::ST_ARMED: begin
                if (roll < 55) begin
                    ev.kind = asc_pkg::KIND_CHECK;
                    if (roll < 40) begin
                        ev.hours   = wake_hour;
                        ev.minutes = wake_minute;
                    end
                end else if (roll < 75) begin
                    ev.kind = asc_pkg::KIND_SET;
                end else if (roll < 90) begin
                    ev.kind = pick_step_kind();
                end else if (roll < 95) begin
                    ev.kind = asc_pkg::KIND_ENABLE;
                end else begin
                    ev.kind = kind_bits_t'($urandom_range(asc_pkg::KIND_DISMISS,
                                                          asc_pkg::KIND_SNOOZE));
                end
            end
            asc_pkg::ST_RINGING: begin
                if (roll < 45)
                    ev.kind = asc_pkg::KIND_SNOOZE;
                else if (roll < 75)
                    ev.kind = asc_pkg::KIND_DISMISS;
                else if (roll < 85)
                    ev.kind = asc_pkg::KIND_CHECK;
                else if (roll < 90)
                    ev.kind = asc_pkg::KIND_ENABLE;
                else
                    ev.kind = kind_bits_t'($urandom_range(asc_pkg::KIND_SET,
                                                          asc_pkg::KIND_IDLE));
            end
            default: begin
                if (roll < 55) begin
                    ev.kind = asc_pkg::KIND_CHECK;
                    if (roll < 40) begin
                        ev.hours   = snooze_hour;
                        ev.minutes = snooze_minute;
                    end
                end else if (roll < 70) begin
                    ev.kind = asc_pkg::KIND_DISMISS;
                end else if (roll < 85) begin
                    ev.kind = pick_step_kind();
                end else if (roll < 90) begin
                    ev.kind = asc_pkg::KIND_SET;
                end else begin
                    ev.kind = kind_bits_t'($urandom_range(asc_pkg::KIND_ENABLE,
                                                          asc_pkg::KIND_SNOOZE));
                end
            end
        endcase
        return ev;
    endfunction

    task automatic send_event(input asc_pkg::asc_in_t ev);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 16) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_payload <= ev;
        do @(posedge aclk); while (!s_ready);
        expected_status.push_back(advance_alarm(ev));
    endtask

    task automatic test_directed_events();
        idle_on = 1'b1;
        send_event(make_event(asc_pkg::KIND_IDLE, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_ENABLE, 0, 0, 1'b1));
        send_event(make_event(asc_pkg::KIND_SET, 31, 63, 1'b1));
        send_event(make_event(asc_pkg::KIND_CHECK, 7, 3, 1'b0));
        send_event(make_event(asc_pkg::KIND_CHECK, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_ENABLE, 31, 63, 1'b1));
        send_event(make_event(asc_pkg::KIND_SNOOZE, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_DEC_HOUR, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_CHECK, 7, 12, 1'b0));
        send_event(make_event(asc_pkg::KIND_DISMISS, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_DISMISS, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_SNOOZE, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_SET, 23, 55, 1'b0));
        send_event(make_event(asc_pkg::KIND_CHECK, 23, 55, 1'b0));
        send_event(make_event(asc_pkg::KIND_SNOOZE, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_CHECK, 0, 4, 1'b0));
        send_event(make_event(asc_pkg::KIND_SET, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_DEC_HOUR, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_DEC_MIN, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_INC_HOUR, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_INC_MIN, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_ENABLE, 0, 0, 1'b0));
        send_event(make_event(asc_pkg::KIND_CHECK, 0, 0, 1'b0));
        send_event(make_event(KIND_UNUSED, 31, 63, 1'b1));
        send_event(make_event(asc_pkg::KIND_ENABLE, 0, 0, 1'b1));
        send_event(make_event(asc_pkg::KIND_CHECK, 31, 63, 1'b1));
    endtask

    task automatic test_random_events(input int count, input bit with_idle);
        idle_on = with_idle;
        repeat (count) send_event(pick_event());
    endtask

    task automatic test_drain_pause();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_status.size() != 0);
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no pending event: state %0d hour %0d minute %0d",
                             $realtime, m_payload.ctl_state, m_payload.alarm_hour,
                             m_payload.alarm_minute);
            end else begin
                want = expected_status.pop_front();
                if (m_payload !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch state %0d/%0d buzzer %0d/%0d enabled %0d/%0d",
                                  " hour %0d/%0d minute %0d/%0d (expected/actual)"},
                                 $realtime, want.ctl_state, m_payload.ctl_state,
                                 want.buzzer_on, m_payload.buzzer_on,
                                 want.enabled, m_payload.enabled,
                                 want.alarm_hour, m_payload.alarm_hour,
                                 want.alarm_minute, m_payload.alarm_minute);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_alarm_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_events();
        test_random_events(600, 1'b1);
        test_drain_pause();
        test_random_events(300, 1'b0);
        test_random_events(350, 1'b1);
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
